### sv/dopcs_pkg.sv
// Shared types, constants and helper functions for the DRAM open-page
// command sequencer. No dependencies; every other file imports this package.
package dopcs_pkg;

	localparam int ROW_BITS      = 20;
	localparam int COLUMN_BITS   = 12;
	localparam int ARG_BITS      = 20;
	localparam int CFG_BITS      = 8;
	localparam int CFG_IDX_BITS  = 3;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = 2;
	localparam int NUM_SLOTS     = 9;
	localparam int SLOT_IDX_BITS = 4;

	typedef enum logic [2:0] {
		CMD_ACT  = 3'd0,
		CMD_RD   = 3'd1,
		CMD_WR   = 3'd2,
		CMD_PRE  = 3'd3,
		CMD_IDLE = 3'd4
	} dram_cmd_t;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVATE_IDLE  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROW_ACTIVE_MIN = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PRECHARGE_IDLE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TURNAROUND     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_READ_PRE_MIN   = 3'd4;

	// command slots of one request, in emission order
	localparam logic [SLOT_IDX_BITS-1:0] SLOT_CLOSE_IDLE = 4'd0;
	localparam logic [SLOT_IDX_BITS-1:0] SLOT_PRE        = 4'd1;
	localparam logic [SLOT_IDX_BITS-1:0] SLOT_PRE_IDLE   = 4'd2;
	localparam logic [SLOT_IDX_BITS-1:0] SLOT_ACT        = 4'd3;
	localparam logic [SLOT_IDX_BITS-1:0] SLOT_ACT_IDLE   = 4'd4;
	localparam logic [SLOT_IDX_BITS-1:0] SLOT_TURN       = 4'd5;
	localparam logic [SLOT_IDX_BITS-1:0] SLOT_ACCESS     = 4'd6;
	localparam logic [SLOT_IDX_BITS-1:0] SLOT_LAST_IDLE  = 4'd7;
	localparam logic [SLOT_IDX_BITS-1:0] SLOT_LAST_PRE   = 4'd8;

	typedef logic [CFG_BITS-1:0] cyc_t;

	typedef struct packed {
		cyc_t activate_idle;
		cyc_t row_active_min;
		cyc_t precharge_idle;
		cyc_t turnaround;
		cyc_t read_pre_min;
	} cfg_t;

	typedef struct packed {
		logic [NUM_SLOTS-1:0]   slots;
		cyc_t                   close_idle;
		cyc_t                   last_idle;
		logic                   is_store;
		logic [ROW_BITS-1:0]    row;
		logic [COLUMN_BITS-1:0] col;
	} plan_t;

	typedef struct packed {
		logic en;
		cyc_t val;
	} wait_t;

	function automatic cyc_t sat_add(cyc_t a, cyc_t b);
		logic [CFG_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[CFG_BITS] ? '1 : sum[CFG_BITS-1:0];
	endfunction

	// wait before precharge, from the last access kind and elapsed count
	function automatic wait_t close_wait(logic prev_read, cyc_t elapsed, cfg_t cfg);
		logic [CFG_BITS:0] sum;
		wait_t             w;
		sum   = {1'b0, elapsed} + {1'b0, cfg.read_pre_min};
		w.en  = 1'b1;
		w.val = cfg.row_active_min - elapsed;
		if (prev_read) begin
			if (sum > {1'b0, cfg.row_active_min}) begin
				w.val = cfg.read_pre_min;
			end
		end else if (elapsed >= cfg.row_active_min) begin
			w.en = 1'b0;
		end
		return w;
	endfunction

endpackage

### sv/dopcs_req_if.sv
// Request channel: valid/ready plus one load or store request.
// Depends on dopcs_pkg.
interface dopcs_req_if;
	import dopcs_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   command;
	logic [ROW_BITS-1:0]    row_address;
	logic [COLUMN_BITS-1:0] column_address;
	logic                   last_request;

	modport source (output valid, output command, output row_address,
		output column_address, output last_request, input ready);
	modport sink (input valid, input command, input row_address,
		input column_address, input last_request, output ready);
endinterface

### sv/dopcs_cmd_if.sv
// Command channel: valid/ready plus one DRAM command.
// Depends on dopcs_pkg.
interface dopcs_cmd_if;
	import dopcs_pkg::*;

	logic                valid;
	logic                ready;
	dram_cmd_t           dram_command;
	logic [ARG_BITS-1:0] argument;
	logic                last_of_run;

	modport source (output valid, output dram_command, output argument,
		output last_of_run, input ready);
	modport sink (input valid, input dram_command, input argument,
		input last_of_run, output ready);
endinterface

### sv/dopcs_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
// Depends on dopcs_pkg.
interface dopcs_cfg_if;
	import dopcs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [CFG_BITS-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### sv/dopcs_front.sv
// Front end: configuration registers, open-row tracking, and classification
// of each request into a command plan. Depends on dopcs_pkg and the interfaces.
module dopcs_front (
	input  logic              clk,
	input  logic              arst_n,
	dopcs_req_if.sink         req,
	dopcs_cfg_if.sink         cfg,
	output logic              push,
	output dopcs_pkg::plan_t  push_data,
	input  logic              full,
	output dopcs_pkg::cfg_t   cfg_regs
);
	import dopcs_pkg::*;

	cfg_t                cfg_q;
	logic                open_q;
	logic [ROW_BITS-1:0] row_q;
	logic                prev_read_q;
	cyc_t                elapsed_q;

	logic  hit;
	logic  turn;
	cyc_t  e1;
	cyc_t  e2;
	wait_t miss_w;
	wait_t last_w;
	plan_t plan;

	assign cfg.ready = 1'b1;
	assign req.ready = !full;
	assign push      = req.valid && !full;
	assign cfg_regs  = cfg_q;

	always_comb begin
		hit    = open_q && (req.row_address == row_q);
		turn   = hit && req.command && prev_read_q;
		miss_w = close_wait(prev_read_q, elapsed_q, cfg_q);
		if (!hit) begin
			e1 = sat_add(cfg_q.activate_idle, cyc_t'(1));
		end else if (turn) begin
			e1 = sat_add(elapsed_q, cfg_q.turnaround);
		end else begin
			e1 = elapsed_q;
		end
		e2     = sat_add(e1, cyc_t'(1));
		last_w = close_wait(!req.command, e2, cfg_q);

		plan                        = '0;
		plan.slots[SLOT_CLOSE_IDLE] = !hit && open_q && miss_w.en;
		plan.slots[SLOT_PRE]        = !hit && open_q;
		plan.slots[SLOT_PRE_IDLE]   = !hit && open_q;
		plan.slots[SLOT_ACT]        = !hit;
		plan.slots[SLOT_ACT_IDLE]   = !hit;
		plan.slots[SLOT_TURN]       = turn;
		plan.slots[SLOT_ACCESS]     = 1'b1;
		plan.slots[SLOT_LAST_IDLE]  = req.last_request && last_w.en;
		plan.slots[SLOT_LAST_PRE]   = req.last_request;
		plan.close_idle             = miss_w.val;
		plan.last_idle              = last_w.val;
		plan.is_store               = req.command;
		plan.row                    = req.row_address;
		plan.col                    = req.column_address;
	end

	assign push_data = plan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.activate_idle  <= cyc_t'(11);
			cfg_q.row_active_min <= cyc_t'(30);
			cfg_q.precharge_idle <= cyc_t'(19);
			cfg_q.turnaround     <= cyc_t'(3);
			cfg_q.read_pre_min   <= cyc_t'(2);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ACTIVATE_IDLE:  cfg_q.activate_idle  <= cfg.data;
				REG_ROW_ACTIVE_MIN: cfg_q.row_active_min <= cfg.data;
				REG_PRECHARGE_IDLE: cfg_q.precharge_idle <= cfg.data;
				REG_TURNAROUND:     cfg_q.turnaround     <= cfg.data;
				REG_READ_PRE_MIN:   cfg_q.read_pre_min   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			row_q       <= '0;
			prev_read_q <= 1'b0;
			elapsed_q   <= '0;
		end else if (push) begin
			open_q      <= !req.last_request;
			row_q       <= req.row_address;
			prev_read_q <= !req.command;
			elapsed_q   <= req.last_request ? '0 : e2;
		end
	end

	a_closed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> elapsed_q == '0)
		else $error("elapsed count nonzero with no open row");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		push && req.last_request |=> !open_q)
		else $error("row left open after last request");

	a_plan_tail: assert property (@(posedge clk) disable iff (!arst_n)
		push && plan.slots[SLOT_ACT] |-> plan.slots[SLOT_ACT_IDLE] && !plan.slots[SLOT_TURN])
		else $error("activate planned without its idle, or with a turnaround");

endmodule

### sv/dopcs_fifo.sv
// Short plan queue between front and back end.
// Depends on dopcs_pkg.
module dopcs_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dopcs_pkg::plan_t wdata,
	output logic             full,
	input  logic             pop,
	output dopcs_pkg::plan_t rdata,
	output logic             empty
);
	import dopcs_pkg::*;

	plan_t                    mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_PTR_BITS:0]   count_q;

	assign full  = count_q == (FIFO_PTR_BITS+1)'(FIFO_DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("plan queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("plan queue underflow");

endmodule

### sv/dopcs_back.sv
// Back end: expands one plan into DRAM commands, one per cycle unless cmd stalls,
// through an output register. Depends on dopcs_pkg and dopcs_cmd_if.
module dopcs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  dopcs_pkg::cfg_t  cfg_regs,
	input  logic             empty,
	input  dopcs_pkg::plan_t rdata,
	output logic             pop,
	dopcs_cmd_if.source      cmd
);
	import dopcs_pkg::*;

	logic [NUM_SLOTS-1:0]     cur_slots_q;
	plan_t                    cur_q;
	logic                     o_valid_q;
	dram_cmd_t                o_cmd_q;
	logic [ARG_BITS-1:0]      o_arg_q;
	logic                     o_last_q;

	logic                     busy;
	logic                     advance;
	logic                     emit;
	logic [SLOT_IDX_BITS-1:0] sel_idx;
	logic [NUM_SLOTS-1:0]     rest;
	dram_cmd_t                n_cmd;
	logic [ARG_BITS-1:0]      n_arg;

	assign busy    = |cur_slots_q;
	assign advance = !o_valid_q || cmd.ready;
	assign emit    = advance && busy;
	assign pop     = !empty && (!busy || (emit && rest == '0));

	always_comb begin
		sel_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (cur_slots_q[i]) begin
				sel_idx = SLOT_IDX_BITS'(i);
			end
		end
		rest = cur_slots_q & ~(NUM_SLOTS'(1) << sel_idx);

		case (sel_idx)
			SLOT_CLOSE_IDLE: begin
				n_cmd = CMD_IDLE;
				n_arg = ARG_BITS'(cur_q.close_idle);
			end
			SLOT_PRE, SLOT_LAST_PRE: begin
				n_cmd = CMD_PRE;
				n_arg = '0;
			end
			SLOT_PRE_IDLE: begin
				n_cmd = CMD_IDLE;
				n_arg = ARG_BITS'(cfg_regs.precharge_idle);
			end
			SLOT_ACT: begin
				n_cmd = CMD_ACT;
				n_arg = ARG_BITS'(cur_q.row);
			end
			SLOT_ACT_IDLE: begin
				n_cmd = CMD_IDLE;
				n_arg = ARG_BITS'(cfg_regs.activate_idle);
			end
			SLOT_TURN: begin
				n_cmd = CMD_IDLE;
				n_arg = ARG_BITS'(cfg_regs.turnaround);
			end
			SLOT_ACCESS: begin
				n_cmd = cur_q.is_store ? CMD_WR : CMD_RD;
				n_arg = ARG_BITS'(cur_q.col);
			end
			SLOT_LAST_IDLE: begin
				n_cmd = CMD_IDLE;
				n_arg = ARG_BITS'(cur_q.last_idle);
			end
			default: begin
				n_cmd = CMD_IDLE;
				n_arg = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_slots_q <= '0;
			o_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				cur_slots_q <= rdata.slots;
			end else if (emit) begin
				cur_slots_q <= rest;
			end
			if (advance) begin
				o_valid_q <= busy;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= rdata;
		end
		if (emit) begin
			o_cmd_q  <= n_cmd;
			o_arg_q  <= n_arg;
			o_last_q <= rest == '0;
		end
	end

	assign cmd.valid        = o_valid_q;
	assign cmd.dram_command = o_cmd_q;
	assign cmd.argument     = o_arg_q;
	assign cmd.last_of_run  = o_last_q;

	a_plan_has_access: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> cur_slots_q[SLOT_ACCESS])
		else $error("plan loaded without an access");

	a_act_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q && o_cmd_q == CMD_ACT |-> !o_last_q)
		else $error("activate marked as last of run");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q && o_last_q |->
			o_cmd_q == CMD_RD || o_cmd_q == CMD_WR || o_cmd_q == CMD_PRE)
		else $error("run ends on an unexpected command");

endmodule

### sv/dram_open_page_command_sequencer.sv
// Top level of the DRAM open-page command sequencer.
// Depends on dopcs_pkg, the channel interfaces, dopcs_front, dopcs_fifo, dopcs_back.
//
// Usage:
//   req  - load/store requests (row, column, last mark); a transfer happens
//          when valid and ready are both high. Ready drops only when the
//          four-entry plan queue is full.
//   cmd  - DRAM commands, one transfer per cycle at most, each with its
//          argument and a last_of_run flag on the final command of a request.
//   cfg  - register writes (index, data); always ready. Write only while idle.
// Path: a request passes through the plan queue, the back end's current plan
//   register and the output register before its first command is valid.
// Commands: one per cycle on cmd while cmd.ready allows; a request causes from
//   1 (a row hit without turnaround or last mark) up to 8 (a row miss marked last).
//   The command expander in the back end produces them.
// Reset: no row open, elapsed count zero, registers at their defaults,
//   queue and output empty.
// Stall: when cmd.ready is low the output holds; the front keeps taking
//   requests until the queue fills.
module dram_open_page_command_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	dopcs_req_if.sink   req,
	dopcs_cmd_if.source cmd,
	dopcs_cfg_if.sink   cfg
);
	import dopcs_pkg::*;

	logic  push;
	plan_t push_data;
	logic  full;
	logic  pop;
	plan_t rdata;
	logic  empty;
	cfg_t  cfg_regs;

	dopcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.cfg_regs  (cfg_regs)
	);

	dopcs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.full   (full),
		.pop    (pop),
		.rdata  (rdata),
		.empty  (empty)
	);

	dopcs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_regs),
		.empty    (empty),
		.rdata    (rdata),
		.pop      (pop),
		.cmd      (cmd)
	);

endmodule
